// ===== rtl/lzwc_pkg.sv =====
// Shared types and constants of the 12-bit LZW compressor.
`timescale 1ns / 1ps
package lzwc_pkg;

    localparam int CHAR_W    = 7;    // message character width
    localparam int ALPHABET  = 128;  // end-of-message code; learned codes start above it
    localparam int EPOCH_W   = 4;    // dictionary generation tag stored in every table entry
    localparam int IN_DATA_W = 8;    // character padded to a whole byte

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load_in;     // latch (match, char) key and its hash slot
        logic first;       // start a match from the character
        logic probe_next;  // step to the next table slot
        logic take_hit;    // grow the match to the found code
        logic miss;        // emit match, learn pair, restart from character
        logic emit_match;  // emit pending match before the end code
        logic emit_end;    // emit end code and start a new dictionary
        logic clr_step;    // invalidate one table slot
    } t_cmd;

    // Status from the datapath to the controller
    typedef struct packed {
        logic in_end;      // offered word is an end-of-message request
        logic in_zero;     // offered word is character zero
        logic have_match;  // a match is pending
        logic hit;         // probed slot holds the key
        logic empty;       // probed slot is free
        logic out_free;    // output register can take a word this cycle
        logic clr_last;    // clearing pass is at the last slot
        logic epoch_wrap;  // next dictionary needs a clearing pass
    } t_stat;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_CHECK = 6'b001000,
        S_FLUSH = 6'b010000,
        S_END   = 6'b100000
    } t_state;

endpackage

// ===== rtl/lzw_compressor_12bit_core.sv =====
// Top level of the greedy LZW compressor with fixed-width codes.
// A character that extends the match passes accept, table read and check; each extra linear
// probe repeats read and check, and a miss drives its code word once the output register is free.
// A new character is taken only in idle, after the previous one has finished its table probe.
// An end word yields one or two output words.
// Reset is synchronous, active low; afterwards the table of 2*DICT_SIZE slots (8192 by default)
// is swept, one slot a cycle, before the first word is taken, and again after every 15th end
// of message.
`timescale 1ns / 1ps
module lzw_compressor_12bit_core #(
    parameter int CODE_WIDTH = 12,
    parameter int DICT_SIZE  = 4096
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    input  logic [lzwc_pkg::IN_DATA_W-1:0]      i_s_axis_tdata,  // [6:0] ch, [7] zero
    input  logic                                i_s_axis_tuser,  // [0] req_type
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    output logic [((CODE_WIDTH+7)/8)*8-1:0]     o_m_axis_tdata,  // [CODE_WIDTH-1:0] code, rest zero
    output logic                                o_m_axis_tlast   // last
);
    import lzwc_pkg::*;

    localparam int OUT_W = ((CODE_WIDTH + 7) / 8) * 8;

    t_cmd                  w_cmd;
    t_stat                 w_stat;
    logic [CODE_WIDTH-1:0] w_code;

    lzwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lzwc_dp #(
        .CODE_WIDTH (CODE_WIDTH),
        .DICT_SIZE  (DICT_SIZE)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_req       (i_s_axis_tuser),
        .i_ch        (i_s_axis_tdata[CHAR_W-1:0]),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .o_out_code  (w_code),
        .o_out_last  (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = OUT_W'(w_code);

endmodule

// ===== rtl/lzwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lzwc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/lzwc_ctrl.sv =====
// Controller state machine of the LZW compressor.
`timescale 1ns / 1ps
module lzwc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lzwc_pkg::t_stat i_stat,
    output lzwc_pkg::t_cmd  o_cmd
);
    import lzwc_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == S_IDLE);
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_stat.in_end) begin
                        n_state = i_stat.have_match ? S_FLUSH : S_END;
                    end else if (!i_stat.in_zero) begin
                        if (i_stat.have_match) begin
                            o_cmd.load_in = 1'b1;
                            n_state       = S_READ;
                        end else begin
                            o_cmd.first = 1'b1;
                        end
                    end
                end
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_stat.hit) begin
                    o_cmd.take_hit = 1'b1;
                    n_state        = S_IDLE;
                end else if (i_stat.empty) begin
                    // hold the probe result until the output register frees up
                    if (i_stat.out_free) begin
                        o_cmd.miss = 1'b1;
                        n_state    = S_IDLE;
                    end
                end else begin
                    o_cmd.probe_next = 1'b1;
                    n_state          = S_READ;
                end
            end
            S_FLUSH: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_match = 1'b1;
                    n_state          = S_END;
                end
            end
            S_END: begin
                if (i_stat.out_free) begin
                    o_cmd.emit_end = 1'b1;
                    n_state        = i_stat.epoch_wrap ? S_CLEAR : S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    a_check_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> $past(r_state == S_READ) || $past(r_state == S_CHECK))
        else $error("probe check without a table read");

endmodule

// ===== rtl/lzwc_dp.sv =====
// Datapath of the LZW compressor: match state, hash table probing and output register.
`timescale 1ns / 1ps
module lzwc_dp #(
    parameter int CODE_WIDTH = 12,
    parameter int DICT_SIZE  = 4096
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  lzwc_pkg::t_cmd                 i_cmd,
    output lzwc_pkg::t_stat                o_stat,
    input  logic                           i_req,
    input  logic [lzwc_pkg::CHAR_W-1:0]    i_ch,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [CODE_WIDTH-1:0]          o_out_code,
    output logic                           o_out_last
);
    import lzwc_pkg::*;

    localparam int HW = $clog2(DICT_SIZE) + 1;        // table has at least twice the codes
    localparam int NW = $clog2(DICT_SIZE) + 1;        // next code, may equal DICT_SIZE
    localparam int KW = CODE_WIDTH + CHAR_W;
    localparam int EW = EPOCH_W + KW + CODE_WIDTH;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    logic [CODE_WIDTH-1:0] r_match;
    logic                  r_have;
    logic [NW-1:0]         r_next;
    logic [EPOCH_W-1:0]    r_epoch;
    logic [HW-1:0]         r_addr;
    logic [KW-1:0]         r_key;
    logic                  r_out_valid;
    logic [CODE_WIDTH-1:0] r_out_code;
    logic                  r_out_last;

    logic [HW-1:0]         w_hash;
    logic                  w_full;
    logic                  w_we;
    logic [EW-1:0]         w_wdata;
    logic [EW-1:0]         w_rdata;
    logic [EPOCH_W-1:0]    w_rd_epoch;
    logic [KW-1:0]         w_rd_key;
    logic [CODE_WIDTH-1:0] w_rd_code;
    logic                  w_hit;
    logic                  w_empty;
    logic                  w_out_free;
    logic                  w_out_ld;

    assign w_hash  = HW'(r_match) ^ (HW'(i_ch) << (HW - CHAR_W));
    assign w_full  = (r_next == NW'(DICT_SIZE));
    assign w_we    = i_cmd.clr_step || (i_cmd.miss && !w_full);
    assign w_wdata = i_cmd.clr_step ? '0 : {r_epoch, r_key, CODE_WIDTH'(r_next)};

    lzwc_ram #(
        .WIDTH (EW),
        .DEPTH (2 ** HW)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_addr),
        .i_wdata (w_wdata),
        .i_raddr (r_addr),
        .o_rdata (w_rdata)
    );

    assign w_rd_epoch = w_rdata[EW-1 -: EPOCH_W];
    assign w_rd_key   = w_rdata[CODE_WIDTH +: KW];
    assign w_rd_code  = w_rdata[CODE_WIDTH-1:0];
    // slots tagged with an older generation count as free
    assign w_empty    = (w_rd_epoch != r_epoch);
    assign w_hit      = !w_empty && (w_rd_key == r_key);

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_out_ld   = i_cmd.miss || i_cmd.emit_match || i_cmd.emit_end;

    always_comb begin
        o_stat            = '0;
        o_stat.in_end     = i_req;
        o_stat.in_zero    = (i_ch == '0);
        o_stat.have_match = r_have;
        o_stat.hit        = w_hit;
        o_stat.empty      = w_empty;
        o_stat.out_free   = w_out_free;
        o_stat.clr_last   = &r_addr;
        o_stat.epoch_wrap = (r_epoch == EPOCH_MAX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match     <= '0;
            r_have      <= 1'b0;
            r_next      <= NW'(ALPHABET + 1);
            r_epoch     <= EPOCH_W'(1);
            r_addr      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_out_ld) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.first) begin
                r_match <= CODE_WIDTH'(i_ch);
                r_have  <= 1'b1;
            end
            if (i_cmd.load_in) begin
                r_addr <= w_hash;
            end
            if (i_cmd.probe_next || i_cmd.clr_step) begin
                r_addr <= r_addr + HW'(1);
            end
            if (i_cmd.take_hit) begin
                r_match <= w_rd_code;
            end
            if (i_cmd.miss) begin
                r_match <= CODE_WIDTH'(r_key[CHAR_W-1:0]);
                if (!w_full) begin
                    r_next <= r_next + NW'(1);
                end
            end
            if (i_cmd.emit_end) begin
                r_match <= '0;
                r_have  <= 1'b0;
                r_next  <= NW'(ALPHABET + 1);
                r_addr  <= '0;
                r_epoch <= (r_epoch == EPOCH_MAX) ? EPOCH_W'(1) : r_epoch + EPOCH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_key <= {r_match, i_ch};
        end
        if (w_out_ld) begin
            r_out_code <= i_cmd.emit_end ? CODE_WIDTH'(ALPHABET) : r_match;
            r_out_last <= i_cmd.emit_end;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_code  = r_out_code;
    assign o_out_last  = r_out_last;

    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_ld |-> w_out_free)
        else $error("output word overwritten before it was taken");

    a_learn_into_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.miss |-> (w_empty && !w_hit))
        else $error("pair learned into an occupied slot");

    a_next_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next <= NW'(DICT_SIZE))
        else $error("next code ran past the dictionary size");

    a_epoch_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != '0)
        else $error("live generation equals the cleared tag");

    a_hit_learned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.take_hit |=> (r_match > CODE_WIDTH'(ALPHABET)))
        else $error("table hit returned a character code");

endmodule
